[src/fetch_locality_histogram_top_defines.svh]
// assertion macros used by the checker file of the locality profiler
`ifndef FETCH_LOCALITY_HISTOGRAM_TOP_DEFINES_SVH
`define FETCH_LOCALITY_HISTOGRAM_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk and quiet while rst_n is low
`define FLH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk and quiet while rst_n is low
`define FLH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/flh_pkg.sv]
// shared types, constants and helpers of the locality profiler
`default_nettype none

package flh_pkg;

  localparam int ADDR_W      = 64;
  localparam int BIN_W       = 5;
  localparam int CNT_W       = 32;
  localparam int LEN_W       = 7;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 2;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * BIN_W - 2 * CNT_W;
  localparam int LEN_STEP0   = ADDR_W / 2;

  // command codes carried on in_tuser
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // bit positions in out_tuser
  localparam int USER_FIRST = 0;
  localparam int USER_FOUND = 1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_ISSUE,
    S_RD_DATA,
    S_FIRST,
    S_SCAN,
    S_HIST_RD,
    S_UPDATE,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic rd_bin;
    logic res_rd;
    logic first_wr;
    logic scan_en;
    logic rd_upd;
    logic upd;
    logic out_load;
  } flh_cmd_t;

  typedef struct packed {
    logic window_empty;
    logic scan_done;
    logic len_done;
    logic out_free;
  } flh_sts_t;

  // number of significant bits of a narrow value
  function automatic logic [4:0] bit_len16(input logic [15:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[src/flh_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module flh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[src/flh_bitlen.sv]
// multi-cycle bit length of a 64-bit value, binary search one halving per cycle
`default_nettype none

module flh_bitlen (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clear,
  input  logic                      start,
  input  logic [flh_pkg::ADDR_W-1:0] value,
  output logic [flh_pkg::LEN_W-1:0]  len,
  output logic                      done
);

  import flh_pkg::*;

  logic [ADDR_W-1:0] val_r, val_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-2:0]  step_r, step_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;

  always_comb begin
    val_nxt  = val_r;
    len_nxt  = len_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    if (clear) begin
      run_nxt  = 1'b0;
      done_nxt = 1'b0;
    end else if (start) begin
      val_nxt  = value;
      len_nxt  = '0;
      step_nxt = (LEN_W-1)'(LEN_STEP0);
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
    end else if (run_r) begin
      if (step_r != '0) begin
        if ((val_r >> step_r) != '0) begin
          val_nxt = val_r >> step_r;
          len_nxt = len_r + LEN_W'(step_r);
        end
        step_nxt = step_r >> 1;
      end else begin
        // value is now 0 or 1
        len_nxt  = len_r + LEN_W'(val_r[0]);
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    val_r  <= val_nxt;
    len_r  <= len_nxt;
    step_r <= step_nxt;
  end

  assign len  = len_r;
  assign done = done_r;

endmodule

`default_nettype wire

[src/flh_ctrl.sv]
// sequencing state machine of the locality profiler
`default_nettype none

module flh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_ready,
  input  flh_pkg::flh_sts_t sts,
  output flh_pkg::flh_cmd_t cmd
);

  import flh_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == CMD_READ) state_nxt = S_RD_ISSUE;
          else if (sts.window_empty) state_nxt = S_FIRST;
          else state_nxt = S_SCAN;
        end
      end
      S_RD_ISSUE: state_nxt = S_RD_DATA;
      S_RD_DATA:  state_nxt = S_OUT;
      S_FIRST:    state_nxt = S_OUT;
      S_SCAN: begin
        if (sts.scan_done && sts.len_done) state_nxt = S_HIST_RD;
      end
      S_HIST_RD:  state_nxt = S_UPDATE;
      S_UPDATE:   state_nxt = S_OUT;
      S_OUT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_RD_ISSUE: cmd.rd_bin   = 1'b1;
      S_RD_DATA:  cmd.res_rd   = 1'b1;
      S_FIRST:    cmd.first_wr = 1'b1;
      S_SCAN:     cmd.scan_en  = 1'b1;
      S_HIST_RD:  cmd.rd_upd   = 1'b1;
      S_UPDATE:   cmd.upd      = 1'b1;
      S_OUT:      cmd.out_load = sts.out_free;
      default:    cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

`default_nettype wire

[src/flh_datapath.sv]
// window scan, histogram memories and result registers of the locality profiler
`default_nettype none

module flh_datapath #(
  parameter int WINDOW_DEPTH = 1022,
  parameter int DIST_BINS    = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  flh_pkg::flh_cmd_t               cmd,
  output flh_pkg::flh_sts_t               sts,
  input  logic [flh_pkg::ADDR_W-1:0]      in_addr,
  input  logic [flh_pkg::BIN_W-1:0]       in_bin,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [flh_pkg::OUT_TUSER_W-1:0] out_user,
  output logic [flh_pkg::OUT_TDATA_W-1:0] out_data
);

  import flh_pkg::*;

  localparam int WIN_AW  = $clog2(WINDOW_DEPTH);
  localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int HIST_AW = $clog2(DIST_BINS);
  localparam logic [LEN_W-1:0] BIN_MAX = LEN_W'(DIST_BINS - 1);

  // latched item
  logic [ADDR_W-1:0] addr_r;
  logic [BIN_W-1:0]  bin_r;

  // window bookkeeping
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [WIN_AW-1:0] newest_r, newest_nxt, newest_dec;

  // scan
  logic [FILL_W-1:0] iss_k_r, iss_k_nxt;
  logic [WIN_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [WIN_AW-1:0] cmp_k_r, cmp_k_nxt;
  logic              scan_done_r, scan_done_nxt;
  logic              found_r, found_nxt;
  logic [WIN_AW-1:0] found_k_r, found_k_nxt;
  logic              len_start;

  // window ram
  logic              win_we, win_re;
  logic [WIN_AW-1:0] win_waddr;
  logic [ADDR_W-1:0] win_q, diff;

  // spatial bit length
  logic [LEN_W-1:0]  slen;
  logic              len_done;

  // bins and histograms
  logic [4:0]         rlen;
  logic [LEN_W-1:0]   rbin_c, sbin_c, rbin_r, sbin_r;
  logic [HIST_AW-1:0] bin_hist, r_raddr, s_raddr;
  logic               hist_re, r_we, s_we;
  logic [CNT_W-1:0]   r_q, s_q, rq, sq, rinc, sinc;
  logic [DIST_BINS-1:0] reuse_vld_r, reuse_vld_nxt, spat_vld_r, spat_vld_nxt;
  logic               rvld_q_r, svld_q_r;
  logic               bin_in_range;

  // result staging and output word
  logic [OUT_TUSER_W-1:0] res_user_r, out_user_r;
  logic [OUT_TDATA_W-1:0] res_data_r, out_data_r;
  logic [OUT_TDATA_W-1:0] rd_word, upd_word;
  logic                   out_vld_r, out_vld_nxt;

  // ---- window scan, newest entry first ----
  always_comb begin
    iss_k_nxt     = iss_k_r;
    rd_ptr_nxt    = rd_ptr_r;
    cmp_vld_nxt   = 1'b0;
    cmp_k_nxt     = cmp_k_r;
    scan_done_nxt = scan_done_r;
    found_nxt     = found_r;
    found_k_nxt   = found_k_r;
    win_re        = 1'b0;
    len_start     = 1'b0;
    if (cmd.load) begin
      iss_k_nxt     = '0;
      rd_ptr_nxt    = newest_r;
      scan_done_nxt = 1'b0;
      found_nxt     = 1'b0;
    end else if (cmd.scan_en && !scan_done_r) begin
      if (iss_k_r < fill_r) begin
        win_re      = 1'b1;
        iss_k_nxt   = iss_k_r + 1'b1;
        rd_ptr_nxt  = (rd_ptr_r == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
        cmp_vld_nxt = 1'b1;
        cmp_k_nxt   = iss_k_r[WIN_AW-1:0];
      end
      if (cmp_vld_r) begin
        // newest entry doubles as the previous fetch address
        if (cmp_k_r == '0) len_start = 1'b1;
        if (win_q == addr_r) begin
          found_nxt     = 1'b1;
          found_k_nxt   = cmp_k_r;
          scan_done_nxt = 1'b1;
        end else if (FILL_W'(cmp_k_r) == fill_r - 1'b1) begin
          scan_done_nxt = 1'b1;
        end
      end
    end
  end

  assign diff = (win_q >= addr_r) ? win_q - addr_r : addr_r - win_q;

  // ---- push front ----
  assign newest_dec = (newest_r == '0) ? WIN_AW'(WINDOW_DEPTH - 1) : newest_r - 1'b1;
  assign win_we     = cmd.first_wr | cmd.upd;
  assign win_waddr  = cmd.upd ? newest_dec : newest_r;

  always_comb begin
    newest_nxt = newest_r;
    fill_nxt   = fill_r;
    if (cmd.first_wr) begin
      fill_nxt = FILL_W'(1);
    end else if (cmd.upd) begin
      newest_nxt = newest_dec;
      if (fill_r != FILL_W'(WINDOW_DEPTH)) fill_nxt = fill_r + 1'b1;
    end
  end

  flh_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (addr_r),
    .re    (win_re),
    .raddr (rd_ptr_r),
    .rdata (win_q)
  );

  flh_bitlen u_len (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (cmd.load),
    .start (len_start),
    .value (diff),
    .len   (slen),
    .done  (len_done)
  );

  // ---- bins ----
  assign rlen   = bit_len16(16'(found_k_r));
  assign rbin_c = (LEN_W'(rlen) > BIN_MAX) ? BIN_MAX : LEN_W'(rlen);
  assign sbin_c = (slen > BIN_MAX) ? BIN_MAX : slen;

  assign bin_hist     = HIST_AW'(bin_r);
  assign bin_in_range = LEN_W'(bin_r) < LEN_W'(DIST_BINS);
  assign hist_re      = cmd.rd_bin | cmd.rd_upd;
  assign r_raddr      = cmd.rd_upd ? rbin_c[HIST_AW-1:0] : bin_hist;
  assign s_raddr      = cmd.rd_upd ? sbin_c[HIST_AW-1:0] : bin_hist;
  assign r_we         = cmd.upd & found_r;
  assign s_we         = cmd.upd;

  // unwritten bins read as zero
  assign rq   = rvld_q_r ? r_q : '0;
  assign sq   = svld_q_r ? s_q : '0;
  assign rinc = (rq == CNT_MAX) ? rq : rq + 1'b1;
  assign sinc = (sq == CNT_MAX) ? sq : sq + 1'b1;

  always_comb begin
    reuse_vld_nxt = reuse_vld_r;
    spat_vld_nxt  = spat_vld_r;
    if (r_we) reuse_vld_nxt[rbin_r[HIST_AW-1:0]] = 1'b1;
    if (s_we) spat_vld_nxt[sbin_r[HIST_AW-1:0]]  = 1'b1;
  end

  flh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DIST_BINS)
  ) u_reuse_hist (
    .clk   (clk),
    .we    (r_we),
    .waddr (rbin_r[HIST_AW-1:0]),
    .wdata (rinc),
    .re    (hist_re),
    .raddr (r_raddr),
    .rdata (r_q)
  );

  flh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DIST_BINS)
  ) u_spat_hist (
    .clk   (clk),
    .we    (s_we),
    .waddr (sbin_r[HIST_AW-1:0]),
    .wdata (sinc),
    .re    (hist_re),
    .raddr (s_raddr),
    .rdata (s_q)
  );

  // ---- result words ----
  assign rd_word = {OUT_PAD_W'(0),
                    bin_in_range ? sq : CNT_W'(0),
                    bin_in_range ? rq : CNT_W'(0),
                    bin_r, bin_r};

  assign upd_word = {OUT_PAD_W'(0),
                     sinc,
                     found_r ? rinc : CNT_W'(0),
                     sbin_r[BIN_W-1:0],
                     found_r ? rbin_r[BIN_W-1:0] : BIN_W'(0)};

  assign out_vld_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      newest_r    <= '0;
      cmp_vld_r   <= 1'b0;
      scan_done_r <= 1'b0;
      found_r     <= 1'b0;
      reuse_vld_r <= '0;
      spat_vld_r  <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      newest_r    <= newest_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      scan_done_r <= scan_done_nxt;
      found_r     <= found_nxt;
      reuse_vld_r <= reuse_vld_nxt;
      spat_vld_r  <= spat_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
    iss_k_r   <= iss_k_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    cmp_k_r   <= cmp_k_nxt;
    found_k_r <= found_k_nxt;
    if (cmd.load) begin
      addr_r <= in_addr;
      bin_r  <= in_bin;
    end
    if (cmd.rd_upd) begin
      rbin_r <= rbin_c;
      sbin_r <= sbin_c;
    end
    if (hist_re) begin
      rvld_q_r <= reuse_vld_r[r_raddr];
      svld_q_r <= spat_vld_r[s_raddr];
    end
    if (cmd.first_wr) begin
      res_user_r <= OUT_TUSER_W'(1) << USER_FIRST;
      res_data_r <= '0;
    end else if (cmd.res_rd) begin
      res_user_r <= '0;
      res_data_r <= rd_word;
    end else if (cmd.upd) begin
      res_user_r <= OUT_TUSER_W'(found_r) << USER_FOUND;
      res_data_r <= upd_word;
    end
    if (cmd.out_load) begin
      out_user_r <= res_user_r;
      out_data_r <= res_data_r;
    end
  end

  assign sts.window_empty = (fill_r == '0);
  assign sts.scan_done    = scan_done_r;
  assign sts.len_done     = len_done;
  assign sts.out_free     = !out_vld_r || out_ready;

  assign out_valid = out_vld_r;
  assign out_user  = out_user_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[src/fetch_locality_histogram_top.sv]
// top level of the instruction fetch locality profiler
//
// fetch locality profiler. each input word is either a record (in_tuser low)
// carrying a fetch address, or a read (in_tuser high) carrying a bin number.
// a record looks the address up in a window of the last WINDOW_DEPTH fetch
// addresses, newest first; a hit at position k bumps reuse bin bitlength(k),
// and the distance to the previous fetch address bumps spatial bin
// bitlength(|diff|), both bins clamped to DIST_BINS-1 and both counters
// saturating. the address is then pushed in front, the oldest dropping out.
// the very first record after reset only fills the window and comes back
// flagged first_fetch. a read returns both counts of one bin (zero beyond
// DIST_BINS) and changes nothing. every word in gives exactly one word out.
// sequencing: one item at a time. a read steps through the issue, data and
// output states, the first record through the write and output states, and
// any other record scans the window until the scan and the spatial bit length
// are both done, then reads and updates the histograms and loads the output.
// the window memory has one read port and the scan compares one entry per
// cycle, while the spatial bit length runs alongside in a 64-bit binary-search
// unit. a finished word waits in the output register while the next word is
// accepted. no clearing pass after reset: the window is tracked by a fill count
// and the histograms by per-bin valid flops, so the block is ready at once.
`default_nettype none

module fetch_locality_histogram_top #(
  parameter int WINDOW_DEPTH = 1022,  // window entries, 2 to 4096
  parameter int DIST_BINS    = 32     // histogram bins, 2 to 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // fetch_address[63:0], bin_index[68:64], zero pad
  input  logic        in_tuser,   // command: record or read
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // reuse_bin[4:0], spatial_bin[9:5], reuse_count[41:10],
                                  // spatial_count[73:42], zero pad
  output logic [1:0]  out_tuser   // first_fetch[0], reuse_found[1]
);

  import flh_pkg::*;

  flh_cmd_t cmd;
  flh_sts_t sts;

  // controller: accepts a word, steps the datapath through scan and update
  flh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: window ram, bit length unit, histogram rams, output register
  flh_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .DIST_BINS    (DIST_BINS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_addr   (in_tdata[ADDR_W-1:0]),
    .in_bin    (in_tdata[ADDR_W+BIN_W-1:ADDR_W]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_user  (out_tuser),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

[src/flh_checker.sv]
// port-level checks of the locality profiler and their binding
`default_nettype none
`include "fetch_locality_histogram_top_defines.svh"

module flh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a waiting result word holds still
  `FLH_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result word changed while stalled")

  // one item at a time: busy right after an accept
  `FLH_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "word accepted while busy")

  // first fetch counts nothing
  `FLH_ASSERT_NOW(a_first_empty, out_tvalid && out_tuser[0], !out_tuser[1] && out_tdata == 80'd0, "first fetch result not empty")

  // a reuse hit always bumps both counters
  `FLH_ASSERT_NOW(a_hit_counts, out_tvalid && out_tuser[1], out_tdata[41:10] != 32'd0 && out_tdata[73:42] != 32'd0, "reuse hit with zero count")

endmodule

bind fetch_locality_histogram_top flh_checker u_flh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
